FILE: rtl/i2cms_pkg.sv
`default_nettype none
package i2cms_pkg;
	localparam int QUEUE_DEPTH_DEF  = 8;
	localparam int BUFFER_BYTES_DEF = 32;

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_ADDR_WR, PH_SENDING, PH_STOP,
		PH_ADDR_RD, PH_READING, PH_READ_LAST, PH_RESTART
	} phase_t;

	// controller sequencing for one input item
	typedef enum logic [1:0] {C_IDLE, C_READ, C_EXEC, C_OUT} cstate_t;

	typedef enum logic [2:0] {
		ACT_LOAD = 3'd0, ACT_SUBMIT = 3'd1, ACT_EVENT = 3'd2, ACT_ERROR = 3'd3,
		ACT_READBACK = 3'd4
	} action_t;

	localparam logic [3:0] CMD_NONE = 4'd0, CMD_START = 4'd1, CMD_ADDR_RD = 4'd2,
		CMD_ADDR_WR = 4'd3, CMD_DATA = 4'd4, CMD_STOP = 4'd5, CMD_ACK_ON = 4'd6,
		CMD_ACK_OFF = 4'd7, CMD_BUF_ON = 4'd8, CMD_BUF_OFF = 4'd9, CMD_IRQ_OFF = 4'd10,
		CMD_RECOVER = 4'd11;

	localparam logic [1:0] KIND_WRITE = 2'd0, KIND_READ = 2'd1, KIND_WR_RD = 2'd2;
	localparam logic [1:0] ST_PENDING = 2'd0, ST_SUCCESS = 2'd1, ST_FAILED = 2'd2;

	localparam int EV_SB = 0, EV_ADDR = 1, EV_TRA = 2, EV_TXE = 3, EV_RXNE = 4,
		EV_BTF = 5;

	// controller -> datapath
	typedef struct packed {
		logic       load_in;      // capture input item
		logic       desc_wr;      // write descriptor at insert slot
		logic       ins_adv;
		logic       ext_adv;
		logic       st_wr;        // write slot status at extract slot
		logic [1:0] st_val;
		logic       mem_rd_rb;    // read address from readback fields
		logic       mem_wr_load;  // write byte_value at insert slot
		logic       mem_wr_rx;    // write rx_byte at extract slot
		logic       bpos_clr;
		logic       bpos_inc;
		logic       bpos_two;
		logic       bpos_one;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic       full;
		logic       empty_after;  // ring empty once extract advances
		logic [1:0] kind;
		logic       wlen_gt1;
		logic       bpos_lt_wlen;
		logic       bpos_lt_rlen;
		logic       bpos1_ge_rlen; // bpos+2 >= rlen (after increment)
		logic       rlen_is1;
		logic       rb_ok;
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/i2cms_ram.sv
`default_nettype none
module i2cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/i2cms_datapath.sv
`default_nettype none
module i2cms_datapath #(
	parameter int QUEUE_DEPTH  = 8,
	parameter int BUFFER_BYTES = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire i2cms_pkg::ctl_t ctl,
	output i2cms_pkg::sts_t    sts,
	input  wire logic [2:0]    slot,
	input  wire logic [4:0]    byte_index,
	input  wire logic [7:0]    byte_value,
	input  wire logic [7:0]    target_addr,
	input  wire logic [1:0]    kind,
	input  wire logic [5:0]    write_len,
	input  wire logic [5:0]    read_len,
	input  wire logic [7:0]    rx_byte,
	output logic [7:0]         addr_byte,
	output logic [7:0]         mem_rdata,
	output logic [1:0]         rb_status,
	output logic [2:0]         insert_slot
);
	import i2cms_pkg::*;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int BW = $clog2(BUFFER_BYTES);
	localparam int LW = $clog2(BUFFER_BYTES + 1);
	localparam int AW = QW + BW;

	typedef struct packed {
		logic [7:0]    addr;
		logic [1:0]    kind;
		logic [LW-1:0] wlen;
		logic [LW-1:0] rlen;
	} desc_t;

	desc_t         desc_q [QUEUE_DEPTH];
	logic [1:0]    stat_q [QUEUE_DEPTH];
	logic [QW-1:0] ins_q, ext_q, ins_nx, ext_nx;
	logic [LW:0]   bpos_q;
	logic [2:0]    slot_q;
	logic [4:0]    bidx_q;
	logic [7:0]    bval_q, addr_q, rx_q;
	logic [1:0]    kind_q;
	logic [5:0]    wlen_q, rlen_q;
	desc_t         cur;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;
	logic [LW:0]   bpos_rd;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			slot_q <= slot; bidx_q <= byte_index; bval_q <= byte_value;
			addr_q <= target_addr; kind_q <= kind; wlen_q <= write_len;
			rlen_q <= read_len; rx_q <= rx_byte;
		end
	end

	assign ins_nx = (32'(ins_q) == QUEUE_DEPTH - 1) ? '0 : ins_q + 1'b1;
	assign ext_nx = (32'(ext_q) == QUEUE_DEPTH - 1) ? '0 : ext_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_q <= '0; ext_q <= '0; bpos_q <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++) stat_q[i] <= ST_PENDING;
		end else begin
			if (ctl.ins_adv) ins_q <= ins_nx;
			if (ctl.ext_adv) ext_q <= ext_nx;
			if (ctl.desc_wr) stat_q[ins_q] <= ST_PENDING;
			if (ctl.st_wr) stat_q[ext_q] <= ctl.st_val;
			if (ctl.bpos_clr) bpos_q <= '0;
			else if (ctl.bpos_two) bpos_q <= (LW+1)'(2);
			else if (ctl.bpos_one) bpos_q <= (LW+1)'(1);
			else if (ctl.bpos_inc) bpos_q <= bpos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.desc_wr) begin
			desc_q[ins_q].addr <= addr_q;
			desc_q[ins_q].kind <= (kind_q == 2'd3) ? KIND_WR_RD : kind_q;
			desc_q[ins_q].wlen <= (32'(wlen_q) > BUFFER_BYTES) ?
				LW'(BUFFER_BYTES) : LW'(wlen_q);
			desc_q[ins_q].rlen <= (32'(rlen_q) > BUFFER_BYTES) ?
				LW'(BUFFER_BYTES) : LW'(rlen_q);
		end
	end

	assign cur = desc_q[ext_q];

	// buffer memory: slot in the high bits, byte position in the low bits
	assign we    = ctl.mem_wr_load ? (32'(bidx_q) < BUFFER_BYTES) :
		ctl.mem_wr_rx && (32'(bpos_q) < BUFFER_BYTES);
	assign waddr = ctl.mem_wr_load ? {ins_q, BW'(bidx_q)} : {ext_q, bpos_q[BW-1:0]};
	assign wdata = ctl.mem_wr_load ? bval_q : rx_q;
	// read position: bpos, or one on the first data byte of a long write
	assign bpos_rd = ctl.bpos_two ? (LW+1)'(1) : bpos_q;
	assign raddr = ctl.mem_rd_rb ? {QW'(slot_q), BW'(bidx_q)} : {ext_q, bpos_rd[BW-1:0]};

	i2cms_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH * BUFFER_BYTES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
		.rdata(mem_rdata)
	);

	assign sts.full          = (ins_nx == ext_q);
	assign sts.empty_after   = (ext_nx == ins_q);
	assign sts.kind          = cur.kind;
	assign sts.wlen_gt1      = cur.wlen > LW'(1);
	assign sts.bpos_lt_wlen  = bpos_q < (LW+1)'(cur.wlen);
	assign sts.bpos_lt_rlen  = bpos_q < (LW+1)'(cur.rlen);
	assign sts.bpos1_ge_rlen = (bpos_q + (LW+1)'(2)) >= (LW+1)'(cur.rlen);
	assign sts.rlen_is1      = cur.rlen == LW'(1);
	assign sts.rb_ok         = (32'(slot_q) < QUEUE_DEPTH) && (32'(bidx_q) < BUFFER_BYTES);
	assign addr_byte   = cur.addr;
	assign rb_status   = (32'(slot_q) < QUEUE_DEPTH) ? stat_q[QW'(slot_q)] : ST_PENDING;
	assign insert_slot = 3'(ins_q);
endmodule
`default_nettype wire

FILE: rtl/i2cms_ctrl.sv
`default_nettype none
module i2cms_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_fire,
	input  wire logic [2:0]      action,
	input  wire logic [5:0]      event_flags,
	input  wire logic [6:0]      error_flags,
	input  wire i2cms_pkg::sts_t sts,
	output i2cms_pkg::ctl_t      ctl,
	output logic                 in_ready,
	output logic                 in_exec,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output logic [3:0]           res_cmd [4],
	output logic [1:0]           res_sel [4],  // byte source: 0 zero, 1 addr&~1, 2 addr|1, 3 mem
	output logic [2:0]           res_n,
	output logic                 res_acc,
	output logic                 res_rb,
	output logic                 busy
);
	import i2cms_pkg::*;

	cstate_t    cs_q, cs_d;
	phase_t     ph_q, ph_d;
	logic [2:0] act_q;
	logic [5:0] ev_q;
	logic [6:0] er_q;
	logic [3:0] cmd_d [4];
	logic [1:0] sel_d [4];
	logic [2:0] n_d;
	logic       acc_d, rb_d;
	logic [3:0] cmd_q [4];
	logic [1:0] sel_q [4];
	logic [2:0] n_q;
	logic       acc_q, rb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= C_IDLE; ph_q <= PH_IDLE; n_q <= '0; acc_q <= 1'b0; rb_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin cmd_q[i] <= CMD_NONE; sel_q[i] <= '0; end
		end else begin
			cs_q <= cs_d;
			if (cs_q == C_EXEC) begin
				ph_q <= ph_d; n_q <= n_d; acc_q <= acc_d; rb_q <= rb_d;
				cmd_q <= cmd_d; sel_q <= sel_d;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (in_fire) begin act_q <= action; ev_q <= event_flags; er_q <= error_flags; end
	end

	always_comb begin
		logic [1:0] k;
		k = '0;
		ctl = '0;
		cs_d = cs_q;
		ph_d = ph_q;
		n_d = '0; acc_d = 1'b0; rb_d = 1'b0;
		for (int i = 0; i < 4; i++) begin cmd_d[i] = CMD_NONE; sel_d[i] = '0; end
		unique case (cs_q)
			C_IDLE: begin
				ctl.load_in = in_fire;
				if (in_fire) cs_d = C_READ;
			end
			C_READ: begin
				// prefetch the buffer byte this item may need
				ctl.mem_rd_rb = (act_q == ACT_READBACK);
				ctl.bpos_two = 1'b0;
				cs_d = C_EXEC;
			end
			C_EXEC: begin
				cs_d = C_OUT;
				case (act_q)
					ACT_LOAD: ctl.mem_wr_load = 1'b1;
					ACT_SUBMIT: if (!sts.full) begin
						ctl.desc_wr = 1'b1; ctl.ins_adv = 1'b1; acc_d = 1'b1;
						if (ph_q == PH_IDLE) begin
							ctl.bpos_clr = 1'b1; ph_d = PH_START;
							cmd_d[k] = CMD_START; k = k + 1'b1;
						end
					end
					ACT_EVENT: begin
						unique case (ph_q)
							PH_IDLE: ;
							PH_START: if (ev_q[EV_SB]) begin
								if (sts.kind == KIND_READ) begin
									cmd_d[k] = CMD_ADDR_RD; sel_d[k] = 2'd2; ph_d = PH_ADDR_RD;
								end else begin
									cmd_d[k] = CMD_ADDR_WR; sel_d[k] = 2'd1; ph_d = PH_ADDR_WR;
								end
								k = k + 1'b1;
							end
							PH_ADDR_WR: if (ev_q[EV_ADDR] && ev_q[EV_TRA]) begin
								cmd_d[k] = CMD_DATA; sel_d[k] = 2'd3; k = k + 1'b1;
								if (sts.wlen_gt1) begin
									// second byte fetched from position one, buffer position set to two
									cmd_d[k] = CMD_DATA; sel_d[k] = 2'd3; k = k + 1'b1;
									cmd_d[k] = CMD_BUF_ON; k = k + 1'b1;
									ctl.bpos_two = 1'b1; ph_d = PH_SENDING;
								end else begin
									ctl.bpos_one = 1'b1;
									if (sts.kind == KIND_WRITE) begin
										cmd_d[k] = CMD_STOP; ph_d = PH_STOP;
									end else begin
										cmd_d[k] = CMD_START; ph_d = PH_RESTART;
									end
									k = k + 1'b1;
								end
							end
							PH_SENDING: if (ev_q[EV_TXE]) begin
								if (sts.bpos_lt_wlen) begin
									cmd_d[k] = CMD_DATA; sel_d[k] = 2'd3; k = k + 1'b1;
									ctl.bpos_inc = 1'b1;
								end else begin
									cmd_d[k] = CMD_BUF_OFF; k = k + 1'b1;
									if (sts.kind == KIND_WRITE) begin
										cmd_d[k] = CMD_STOP; ph_d = PH_STOP;
									end else begin
										cmd_d[k] = CMD_START; ph_d = PH_RESTART;
									end
									k = k + 1'b1;
								end
							end
							PH_STOP: begin
								ctl.mem_wr_rx = ev_q[EV_RXNE] && sts.bpos_lt_rlen;
								cmd_d[k] = CMD_IRQ_OFF; k = k + 1'b1;
								ctl.st_wr = 1'b1; ctl.st_val = ST_SUCCESS; ctl.ext_adv = 1'b1;
								if (sts.empty_after) ph_d = PH_IDLE;
								else begin
									ctl.bpos_clr = 1'b1; ph_d = PH_START;
									cmd_d[k] = CMD_START; k = k + 1'b1;
								end
							end
							PH_ADDR_RD: if (ev_q[EV_ADDR] && !ev_q[EV_TRA]) begin
								ctl.bpos_clr = 1'b1;
								if (sts.rlen_is1) begin
									cmd_d[0] = CMD_ACK_OFF; cmd_d[1] = CMD_STOP; ph_d = PH_READ_LAST;
								end else begin
									cmd_d[0] = CMD_ACK_ON; cmd_d[1] = CMD_BUF_ON; ph_d = PH_READING;
								end
								k = 2'd2;
							end
							PH_READING: if (ev_q[EV_RXNE] && sts.bpos_lt_rlen) begin
								ctl.mem_wr_rx = 1'b1; ctl.bpos_inc = 1'b1;
								if (sts.bpos1_ge_rlen) begin
									cmd_d[0] = CMD_ACK_OFF; cmd_d[1] = CMD_STOP; k = 2'd2;
									ph_d = PH_STOP;
								end
							end
							PH_READ_LAST: begin
								if (ev_q[EV_BTF]) begin
									ctl.mem_wr_rx = 1'b1; cmd_d[k] = CMD_STOP; k = k + 1'b1;
									ph_d = PH_STOP;
								end else if (ev_q[EV_RXNE]) begin
									ctl.mem_wr_rx = 1'b1; ph_d = PH_STOP;
								end
							end
							PH_RESTART: if (ev_q[EV_SB]) begin
								cmd_d[k] = CMD_ADDR_RD; sel_d[k] = 2'd2; k = k + 1'b1;
								ph_d = PH_ADDR_RD;
							end
							default: ;
						endcase
					end
					ACT_ERROR: begin
						if (er_q[0]) begin cmd_d[k] = CMD_STOP; k = k + 1'b1; end
						cmd_d[k] = CMD_RECOVER; k = k + 1'b1;
						if (ph_q != PH_IDLE) begin
							ctl.st_wr = 1'b1; ctl.st_val = ST_FAILED; ctl.ext_adv = 1'b1;
							if (sts.empty_after) ph_d = PH_IDLE;
							else begin
								ctl.bpos_clr = 1'b1; ph_d = PH_START;
								cmd_d[k] = CMD_START; k = k + 1'b1;
							end
						end
					end
					ACT_READBACK: rb_d = 1'b1;
					default: ;
				endcase
				if (k == '0) k = 2'd1;
				n_d = {1'b0, k};
			end
			C_OUT: if (res_ready) cs_d = C_IDLE;
			default: cs_d = C_IDLE;
		endcase
	end

	assign in_ready  = (cs_q == C_IDLE);
	assign in_exec   = (cs_q == C_EXEC);
	assign res_valid = (cs_q == C_OUT);
	assign res_cmd   = cmd_q;
	assign res_sel   = sel_q;
	assign res_n     = n_q;
	assign res_acc   = acc_q;
	assign res_rb    = rb_q;
	assign busy      = (ph_q != PH_IDLE);

`ifndef SYNTHESIS
	a_out_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (n_q != 3'd0 && n_q <= 3'd4)) else $error("bad result count");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cs_q != C_IDLE) |-> !in_ready) else $error("accept while busy");
	a_exec_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cs_q == C_EXEC) |=> (cs_q == C_OUT)) else $error("exec did not finish");
`endif
endmodule
`default_nettype wire

FILE: rtl/i2c_master_transaction_sequencer.sv
`default_nettype none
// an input item passes the read and exec states, then gives one result per cycle
// while m_tready is high; a new item is taken once its 1 to 3 results are transferred
// this pacing is set by the one-item controller and the registered buffer memory read
// reset: arst_n asynchronous, clears phase, ring pointers, buffer position, slot status
// descriptor and buffer memories are not cleared and hold garbage until written
module i2c_master_transaction_sequencer #(
	parameter int QUEUE_DEPTH  = i2cms_pkg::QUEUE_DEPTH_DEF,
	parameter int BUFFER_BYTES = i2cms_pkg::BUFFER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// action[2:0] slot[5:3] byte_index[10:6] byte_value[18:11] target_addr[26:19]
	// kind[28:27] write_len[34:29] read_len[40:35] event_flags[46:41]
	// rx_byte[54:47] error_flags[61:55], zero filled
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// command[3:0] command_byte[11:4] accepted[12] slot_used[15:13] data_byte[23:16]
	// slot_status[25:24] busy_res[26], zero filled
	output logic [31:0]      m_tdata,
	output logic             m_tlast
);
	import i2cms_pkg::*;

	ctl_t       ctl;
	sts_t       sts;
	logic       in_fire, in_exec, res_valid, res_acc, res_rb, busy;
	logic [3:0] res_cmd [4];
	logic [1:0] res_sel [4];
	logic [2:0] res_n;
	logic [1:0] k_q;            // result index within this item
	logic [7:0] addr_byte, mem_rdata, mem_q, mem2_q, cbyte, dbyte;
	logic [1:0] rb_status, sstat_q;
	logic [2:0] insert_slot, used_q;
	logic       rb_ok_q;
	logic       second_rd_q;

	assign in_fire = s_tvalid && s_tready;

	i2cms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .action(s_tdata[2:0]),
		.event_flags(s_tdata[46:41]), .error_flags(s_tdata[61:55]), .sts(sts), .ctl(ctl),
		.in_ready(s_tready), .in_exec(in_exec), .res_valid(res_valid),
		.res_ready(m_tready && m_tlast),
		.res_cmd(res_cmd), .res_sel(res_sel), .res_n(res_n), .res_acc(res_acc),
		.res_rb(res_rb), .busy(busy)
	);

	i2cms_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .BUFFER_BYTES(BUFFER_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.slot(s_tdata[5:3]), .byte_index(s_tdata[10:6]), .byte_value(s_tdata[18:11]),
		.target_addr(s_tdata[26:19]), .kind(s_tdata[28:27]), .write_len(s_tdata[34:29]),
		.read_len(s_tdata[40:35]), .rx_byte(s_tdata[54:47]), .addr_byte(addr_byte),
		.mem_rdata(mem_rdata), .rb_status(rb_status), .insert_slot(insert_slot)
	);

	// first byte lands during exec; on a two-byte write start the second read
	// address (position one) is presented in exec and lands during output
	always_ff @(posedge clk) begin
		second_rd_q <= ctl.bpos_two;
		if (in_exec) begin
			mem_q   <= mem_rdata;
			used_q  <= insert_slot;
			rb_ok_q <= sts.rb_ok;
			sstat_q <= rb_status;
		end
		if (second_rd_q) mem2_q <= mem_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= '0;
		else if (m_tvalid && m_tready) k_q <= m_tlast ? '0 : k_q + 1'b1;
	end

	always_comb begin
		case (res_sel[k_q])
			2'd1:    cbyte = {addr_byte[7:1], 1'b0};
			2'd2:    cbyte = {addr_byte[7:1], 1'b1};
			2'd3:    cbyte = (k_q == 2'd1) ? mem2_q : mem_q;
			default: cbyte = 8'd0;
		endcase
	end
	assign dbyte = (res_rb && rb_ok_q) ? mem_q : 8'd0;

	assign m_tvalid = res_valid;
	assign m_tlast  = ({1'b0, k_q} + 3'd1) == res_n;
	assign m_tdata  = {5'd0, busy,
		(k_q == 2'd0 && res_rb) ? sstat_q : 2'd0,
		(k_q == 2'd0) ? dbyte : 8'd0,
		(k_q == 2'd0 && res_acc) ? used_q : 3'd0,
		(k_q == 2'd0) ? res_acc : 1'b0,
		cbyte, res_cmd[k_q]};
endmodule
`default_nettype wire
